// ===== sv/bba_pkg.sv =====
// Shared constants, types and helper functions of the buddy block allocator.
package bba_pkg;

  localparam int ARENA_BYTES = 1048576;
  localparam int NUM_CLASSES = 20;
  localparam int GROW_BYTES  = 4096;
  localparam int INIT_LOG    = 12;

  localparam int ARENA_LOG = $clog2(ARENA_BYTES);
  localparam int GROW_LOG  = $clog2(GROW_BYTES);
  localparam int GRANULES  = ARENA_BYTES / 16;
  localparam int GRAN_W    = $clog2(GRANULES);
  localparam int LINK_W    = GRAN_W + 1;
  localparam int CLS_W     = $clog2(NUM_CLASSES);
  localparam int LOG_W     = 5;
  localparam int HDR_W     = LOG_W + 1;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(GRANULES);

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_ZERO    = 2'd2
  } status_code_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_LOAD, OP_DISPATCH, OP_FIT, OP_WALK_RD, OP_WALK_CHK,
    OP_GROW, OP_PUSH, OP_CHK, OP_CHK2, OP_RM_RD, OP_RM_UPD, OP_RM2,
    OP_MERGE1, OP_MERGE2, OP_PLACE_RM, OP_SPLIT, OP_FREE_RD, OP_FREE_CHK,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic too_big;
    logic cls_last;
    logic head_nonnil;
    logic cur_nil;
    logic walk_fit;
    logic grow_fail;
    logic buddy_out;
    logic buddy_match;
    logic split_more;
    logic free_ok;
    logic free_hit;
    logic clr_last;
  } dp_flags_t;

  // Size class of a block log, clamped to the last class
  function automatic logic [CLS_W-1:0] class_of(input logic [LOG_W-1:0] lg);
    return (32'(lg) > NUM_CLASSES - 1) ? CLS_W'(NUM_CLASSES - 1) : CLS_W'(lg);
  endfunction

  function automatic logic [20:0] pow2(input logic [LOG_W-1:0] lg);
    return 21'(1) << lg;
  endfunction

endpackage

// ===== sv/bba_if.sv =====
// Request and response channel interfaces of the buddy block allocator.
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [20:0] req_bytes;
  logic [19:0] block_offset;

  modport source(output valid, cmd, req_bytes, block_offset, input ready);
  modport sink(input valid, cmd, req_bytes, block_offset, output ready);
endinterface

interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [19:0] granted_offset;
  logic [20:0] granted_bytes;

  modport source(output valid, status, granted_offset, granted_bytes, input ready);
  modport sink(input valid, status, granted_offset, granted_bytes, output ready);
endinterface

// ===== sv/buddy_block_allocator_unit.sv =====
// Sequence: a zero-size or too-large allocate, or a misaligned free, goes straight to the result;
// an allocate is served by the head of its own class, else after scanning empty classes upward, then split;
// the last-class list is walked entry by entry; a free ends with no merge or after each buddy merge.
// One transaction at a time; the next is accepted no earlier than the cycle after the
// result enters the output register.
// Reset: synchronous; a clearing pass sweeps the header memory, no request taken.
module buddy_block_allocator_unit (
  input  logic       clk,
  input  logic       rst,
  bba_req_if.sink    req,
  bba_rsp_if.source  rsp
);

  bba_pkg::ctrl_cmd_t ctrl;
  bba_pkg::dp_flags_t flags;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .flags     (flags),
    .ctrl      (ctrl)
  );

  bba_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .flags           (flags),
    .in_cmd          (req.cmd),
    .in_req_bytes    (req.req_bytes),
    .in_block_offset (req.block_offset),
    .status          (rsp.status),
    .granted_offset  (rsp.granted_offset),
    .granted_bytes   (rsp.granted_bytes)
  );

endmodule

// ===== sv/bba_dp.sv =====
// Datapath of the buddy allocator: header and link memories, list heads, scratch registers.
module bba_dp (
  input  logic                clk,
  input  logic                rst,
  input  bba_pkg::ctrl_cmd_t  ctrl,
  output bba_pkg::dp_flags_t  flags,
  input  logic                in_cmd,
  input  logic [20:0]         in_req_bytes,
  input  logic [19:0]         in_block_offset,
  output logic [1:0]          status,
  output logic [19:0]         granted_offset,
  output logic [20:0]         granted_bytes
);

  localparam int GW = bba_pkg::GRAN_W;
  localparam int LW = bba_pkg::LINK_W;
  localparam int OW = bba_pkg::LOG_W;
  localparam int HW = bba_pkg::HDR_W;

  // Memories
  logic [HW-1:0] hdr_mem [bba_pkg::GRANULES];
  logic [LW-1:0] prv_mem [bba_pkg::GRANULES];
  logic [LW-1:0] nxt_mem [bba_pkg::GRANULES];

  logic [HW-1:0] hdr_rd;
  logic [LW-1:0] prv_rd, nxt_rd;

  // Scratch registers
  logic          cmd_q;
  logic [20:0]   req_q;
  logic [19:0]   off_q;
  logic [OW-1:0] alog, lg;
  logic [bba_pkg::CLS_W-1:0] cls;
  logic [LW-1:0] b, cur, x;
  logic [GW-1:0] left, right;
  logic [20:0]   top;
  logic [LW-1:0] heads [bba_pkg::NUM_CLASSES];
  logic [GW-1:0] clr_cnt;
  logic [1:0]    st;
  logic [19:0]   goff;
  logic [20:0]   gbytes;

  // Memory port controls
  logic          hdr_we, nxt_we, prv_we;
  logic [GW-1:0] hdr_wa, nxt_wa, prv_wa, hdr_ra, lnk_ra;
  logic [HW-1:0] hdr_wd;
  logic [LW-1:0] nxt_wd, prv_wd;
  logic [bba_pkg::CLS_W-1:0] hidx;
  logic [LW-1:0] head_val;

  // Derived values
  logic [21:0]   need;
  logic [OW-1:0] alog_in;
  logic [OW-1:0] glog, lg_dn;
  logic [20:0]   buddy_off;
  logic [GW-1:0] bg;
  logic [LW-1:0] bud;
  logic [21:0]   grow_end;

  // Rounded size class of the incoming request: bit length of req + 7, at least 4
  always_comb begin
    need    = 22'(in_req_bytes) + 22'd7;
    alog_in = OW'(4);
    for (int i = 4; i < 22; i++) begin
      if (need[i]) alog_in = OW'(i + 1);
    end
  end

  assign glog      = (32'(alog) > bba_pkg::GROW_LOG) ? alog : OW'(bba_pkg::GROW_LOG);
  assign lg_dn     = lg - OW'(1);
  assign buddy_off = {b[GW-1:0], 4'b0} ^ bba_pkg::pow2(lg);
  assign bg        = buddy_off[GW+3:4];
  assign bud       = b + (LW'(1) << (lg_dn - OW'(4)));
  assign grow_end  = {1'b0, top} + {1'b0, bba_pkg::pow2(glog)};
  assign head_val  = heads[hidx];

  // Status toward the controller
  always_comb begin
    flags.is_free     = cmd_q;
    flags.zero_req    = (req_q == '0);
    flags.too_big     = (32'(alog) > bba_pkg::ARENA_LOG);
    flags.cls_last    = (32'(cls) == bba_pkg::NUM_CLASSES - 1);
    flags.head_nonnil = (head_val != bba_pkg::NIL);
    flags.cur_nil     = (cur == bba_pkg::NIL);
    flags.walk_fit    = (hdr_rd[HW-1:1] >= alog);
    flags.grow_fail   = (grow_end > 22'(bba_pkg::ARENA_BYTES));
    flags.buddy_out   = (buddy_off >= top);
    flags.buddy_match = (hdr_rd[HW-1:1] == lg) && !hdr_rd[0];
    flags.split_more  = (lg > alog);
    flags.free_ok     = ({1'b0, off_q} < top) && (off_q[3:0] == 4'd0);
    flags.free_hit    = (hdr_rd[HW-1:1] != '0) && hdr_rd[0];
    flags.clr_last    = (clr_cnt == '1);
  end

  // Memory addressing and write data per operation
  always_comb begin
    hdr_we = 1'b0; hdr_wa = b[GW-1:0]; hdr_wd = '0;
    nxt_we = 1'b0; nxt_wa = b[GW-1:0]; nxt_wd = head_val;
    prv_we = 1'b0; prv_wa = head_val[GW-1:0]; prv_wd = b;
    hdr_ra = cur[GW-1:0];
    lnk_ra = cur[GW-1:0];
    hidx   = cls;
    unique case (ctrl.op)
      bba_pkg::OP_CLR: begin
        hdr_we = 1'b1;
        hdr_wa = clr_cnt;
        hdr_wd = (clr_cnt == '0) ? {OW'(bba_pkg::INIT_LOG), 1'b0} : '0;
        nxt_we = (clr_cnt == '0);
        nxt_wa = '0;
        nxt_wd = bba_pkg::NIL;
      end
      bba_pkg::OP_GROW: begin
        hdr_we = !flags.grow_fail;
        hdr_wa = top[GW+3:4];
        hdr_wd = {glog, 1'b0};
      end
      bba_pkg::OP_PUSH: begin
        hidx   = bba_pkg::class_of(lg);
        nxt_we = 1'b1;
        prv_we = (head_val != bba_pkg::NIL);
      end
      bba_pkg::OP_CHK: hdr_ra = bg;
      bba_pkg::OP_RM_RD: lnk_ra = x[GW-1:0];
      bba_pkg::OP_RM_UPD: begin
        hidx = bba_pkg::class_of(lg);
        if (head_val != x) begin
          nxt_we = (prv_rd != bba_pkg::NIL);
          nxt_wa = prv_rd[GW-1:0];
          nxt_wd = nxt_rd;
          prv_we = (nxt_rd != bba_pkg::NIL);
          prv_wa = nxt_rd[GW-1:0];
          prv_wd = prv_rd;
        end
      end
      bba_pkg::OP_MERGE1: begin
        hdr_we = 1'b1;
        hdr_wa = right;
      end
      bba_pkg::OP_MERGE2: begin
        hdr_we = 1'b1;
        hdr_wa = left;
        hdr_wd = {lg + OW'(1), 1'b0};
      end
      bba_pkg::OP_SPLIT: begin
        hidx = bba_pkg::class_of(lg_dn);
        if (flags.split_more) begin
          hdr_we = 1'b1;
          hdr_wa = bud[GW-1:0];
          hdr_wd = {lg_dn, 1'b0};
          nxt_we = 1'b1;
          nxt_wa = bud[GW-1:0];
          prv_we = (head_val != bba_pkg::NIL);
          prv_wd = bud;
        end else begin
          hdr_we = 1'b1;
          hdr_wd = {lg, 1'b1};
        end
      end
      bba_pkg::OP_FREE_RD: hdr_ra = off_q[GW+3:4];
      bba_pkg::OP_FREE_CHK: begin
        hdr_we = flags.free_hit;
        hdr_wa = off_q[GW+3:4];
        hdr_wd = {hdr_rd[HW-1:1], 1'b0};
      end
      default: ;
    endcase
  end

  // Memory ports, registered reads
  always_ff @(posedge clk) begin
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    hdr_rd <= hdr_mem[hdr_ra];
    nxt_rd <= nxt_mem[lnk_ra];
    prv_rd <= prv_mem[lnk_ra];
  end

  // Control state: arena top, list heads, clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      top     <= 21'(1 << bba_pkg::INIT_LOG);
      clr_cnt <= '0;
      for (int i = 0; i < bba_pkg::NUM_CLASSES; i++) begin
        heads[i] <= (i == int'(bba_pkg::class_of(OW'(bba_pkg::INIT_LOG)))) ? '0 : bba_pkg::NIL;
      end
    end else begin
      unique case (ctrl.op)
        bba_pkg::OP_CLR: clr_cnt <= clr_cnt + GW'(1);
        bba_pkg::OP_GROW: if (!flags.grow_fail) top <= grow_end[20:0];
        bba_pkg::OP_PUSH: heads[hidx] <= b;
        bba_pkg::OP_RM_UPD: if (head_val == x) heads[hidx] <= nxt_rd;
        bba_pkg::OP_SPLIT: if (flags.split_more) heads[hidx] <= bud;
        default: ;
      endcase
    end
  end

  // Scratch and result registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      bba_pkg::OP_LOAD: begin
        cmd_q  <= in_cmd;
        req_q  <= in_req_bytes;
        off_q  <= in_block_offset;
        alog   <= alog_in;
        st     <= bba_pkg::ST_OK;
        goff   <= '0;
        gbytes <= '0;
      end
      bba_pkg::OP_DISPATCH: begin
        cls <= bba_pkg::class_of(alog);
        if (!cmd_q) begin
          if (flags.zero_req) st <= bba_pkg::ST_ZERO;
          else if (flags.too_big) st <= bba_pkg::ST_NOSPACE;
        end
      end
      bba_pkg::OP_FIT: begin
        if (flags.cls_last) cur <= head_val;
        else if (flags.head_nonnil) begin
          b  <= head_val;
          lg <= OW'(cls);
        end else cls <= cls + 1'b1;
      end
      bba_pkg::OP_WALK_CHK: begin
        if (flags.walk_fit) begin
          b  <= cur;
          lg <= hdr_rd[HW-1:1];
        end else cur <= nxt_rd;
      end
      bba_pkg::OP_GROW: begin
        if (flags.grow_fail) st <= bba_pkg::ST_NOSPACE;
        else begin
          b  <= {1'b0, top[GW+3:4]};
          lg <= glog;
        end
      end
      bba_pkg::OP_CHK2: begin
        if (flags.buddy_match) begin
          left  <= (bg < b[GW-1:0]) ? bg : b[GW-1:0];
          right <= (bg < b[GW-1:0]) ? b[GW-1:0] : bg;
          x     <= {1'b0, ((bg < b[GW-1:0]) ? bg : b[GW-1:0])};
        end
      end
      bba_pkg::OP_RM2: x <= {1'b0, right};
      bba_pkg::OP_MERGE2: begin
        b  <= {1'b0, left};
        lg <= lg + OW'(1);
      end
      bba_pkg::OP_PLACE_RM: x <= b;
      bba_pkg::OP_SPLIT: begin
        if (flags.split_more) lg <= lg_dn;
        else begin
          goff   <= {b[GW-1:0], 4'b0};
          gbytes <= bba_pkg::pow2(alog);
        end
      end
      bba_pkg::OP_FREE_CHK: begin
        if (flags.free_hit) begin
          b      <= {1'b0, off_q[GW+3:4]};
          lg     <= hdr_rd[HW-1:1];
          goff   <= off_q;
          gbytes <= bba_pkg::pow2(hdr_rd[HW-1:1]);
        end
      end
      bba_pkg::OP_EMIT: begin
        status         <= st;
        granted_offset <= goff;
        granted_bytes  <= gbytes;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // The used top stays granule aligned and inside the arena
  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    top <= 21'(bba_pkg::ARENA_BYTES))
    else $error("arena top past arena end");
  a_top_align: assert property (@(posedge clk) disable iff (rst)
    top[3:0] == 4'd0)
    else $error("arena top not granule aligned");
  // A split never goes below the requested size
  a_split_floor: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == bba_pkg::OP_SPLIT) |-> (lg >= alog))
    else $error("split below requested class");
`endif

endmodule

// ===== sv/bba_ctrl.sv =====
// Controller state machine of the buddy allocator: sequences datapath operations.
module bba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bba_pkg::dp_flags_t flags,
  output bba_pkg::ctrl_cmd_t ctrl
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISPATCH, S_FIT, S_WALK_RD, S_WALK_CHK, S_GROW, S_PUSH,
    S_CHK, S_CHK2, S_RM_RD, S_RM_UPD, S_RM2, S_MERGE1, S_MERGE2, S_PLACE,
    S_SPLIT, S_FREE_RD, S_FREE_CHK, S_RESULT
  } state_t;

  state_t state, ret;
  logic   emit;

  assign in_ready = (state == S_IDLE);
  assign emit     = (state == S_RESULT) && (!out_valid || out_ready);

  // Operation for the datapath in each state
  always_comb begin
    unique case (state)
      S_CLR:      ctrl.op = bba_pkg::OP_CLR;
      S_IDLE:     ctrl.op = in_valid ? bba_pkg::OP_LOAD : bba_pkg::OP_NONE;
      S_DISPATCH: ctrl.op = bba_pkg::OP_DISPATCH;
      S_FIT:      ctrl.op = bba_pkg::OP_FIT;
      S_WALK_RD:  ctrl.op = bba_pkg::OP_WALK_RD;
      S_WALK_CHK: ctrl.op = bba_pkg::OP_WALK_CHK;
      S_GROW:     ctrl.op = bba_pkg::OP_GROW;
      S_PUSH:     ctrl.op = bba_pkg::OP_PUSH;
      S_CHK:      ctrl.op = bba_pkg::OP_CHK;
      S_CHK2:     ctrl.op = bba_pkg::OP_CHK2;
      S_RM_RD:    ctrl.op = bba_pkg::OP_RM_RD;
      S_RM_UPD:   ctrl.op = bba_pkg::OP_RM_UPD;
      S_RM2:      ctrl.op = bba_pkg::OP_RM2;
      S_MERGE1:   ctrl.op = bba_pkg::OP_MERGE1;
      S_MERGE2:   ctrl.op = bba_pkg::OP_MERGE2;
      S_PLACE:    ctrl.op = bba_pkg::OP_PLACE_RM;
      S_SPLIT:    ctrl.op = bba_pkg::OP_SPLIT;
      S_FREE_RD:  ctrl.op = bba_pkg::OP_FREE_RD;
      S_FREE_CHK: ctrl.op = bba_pkg::OP_FREE_CHK;
      S_RESULT:   ctrl.op = emit ? bba_pkg::OP_EMIT : bba_pkg::OP_NONE;
      default:    ctrl.op = bba_pkg::OP_NONE;
    endcase
  end

  // State, return state of the list-remove sequence, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_CLR:  if (flags.clr_last) state <= S_IDLE;
        S_IDLE: if (in_valid) state <= S_DISPATCH;
        S_DISPATCH: begin
          if (flags.is_free) state <= flags.free_ok ? S_FREE_RD : S_RESULT;
          else if (flags.zero_req || flags.too_big) state <= S_RESULT;
          else state <= S_FIT;
        end
        S_FIT: begin
          if (flags.cls_last) state <= S_WALK_RD;
          else if (flags.head_nonnil) state <= S_PLACE;
        end
        S_WALK_RD:  state <= flags.cur_nil ? S_GROW : S_WALK_CHK;
        S_WALK_CHK: state <= flags.walk_fit ? S_PLACE : S_WALK_RD;
        S_GROW:     state <= flags.grow_fail ? S_RESULT : S_PUSH;
        S_PUSH:     state <= S_CHK;
        S_CHK: begin
          if (flags.buddy_out) state <= flags.is_free ? S_RESULT : S_PLACE;
          else state <= S_CHK2;
        end
        S_CHK2: begin
          if (flags.buddy_match) begin
            state <= S_RM_RD;
            ret   <= S_RM2;
          end else state <= flags.is_free ? S_RESULT : S_PLACE;
        end
        S_RM_RD:  state <= S_RM_UPD;
        S_RM_UPD: state <= ret;
        S_RM2: begin
          state <= S_RM_RD;
          ret   <= S_MERGE1;
        end
        S_MERGE1: state <= S_MERGE2;
        S_MERGE2: state <= S_PUSH;
        S_PLACE: begin
          state <= S_RM_RD;
          ret   <= S_SPLIT;
        end
        S_SPLIT:    if (!flags.split_more) state <= S_RESULT;
        S_FREE_RD:  state <= S_FREE_CHK;
        S_FREE_CHK: state <= flags.free_hit ? S_PUSH : S_RESULT;
        S_RESULT:   if (emit) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // No request is taken during the clearing pass
  a_no_accept_clr: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !in_ready)
    else $error("accept during clearing pass");
  // An accepted transaction is dispatched next
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISPATCH))
    else $error("accepted transaction not dispatched");
  // A result is loaded only when the output register is free
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == bba_pkg::OP_EMIT) |-> (!out_valid || out_ready))
    else $error("result overwrites pending output");
`endif

endmodule
